FILE: src/pprb_pkg.sv
// Package with the transfer types, request codes and controller states of the receive buffer.
`timescale 1ns / 1ps
package pprb_pkg;

  // Widths of the item fields.
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;

  // Request codes carried in req_type.
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

  // Result codes carried in result_kind.
  localparam logic [REQ_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [REQ_W-1:0] KIND_EMPTY  = 2'd1;
  localparam logic [REQ_W-1:0] KIND_STATUS = 2'd2;

  // One input item.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic [LEN_W-1:0]  read_len;
    logic              reinit;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [REQ_W-1:0]  result_kind;
    logic [BYTE_W-1:0] out_byte;
    logic              overflow_seen;
    logic              last_of_run;
  } out_item_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_byte;
    logic start_read;
    logic issue;
    logic load_none;
    logic load_check;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stage_free;
    logic n_zero;
    logic n_one;
    logic rem_one;
  } dp_status_t;

endpackage

FILE: src/ping_pong_rx_buffer.sv
// Top level of the double-buffered receive store: controller, datapath and checks.
//
// Usage: items arrive on the in_ channel (valid/ready, payload in_data) and
// results leave on the out_ channel (valid/ready, payload out_data).
// A received byte (req_type 0) gives no result. A check or an empty read gives
// one result, which passes through the result stage and then the output register.
// A read of n bytes gives n results, one per cycle when the receiver keeps
// out_ready high; each is read from the store into the result stage and then moves
// to the output register, and no new item is taken until the last byte has been
// read from the store, so a read occupies the input for the whole run.
// The rate of a run is set by the single registered read port of the ready
// store feeding a one-entry result stage and the output register.
// When the receiver stalls, the result stage and the output register hold
// their contents and the store reads pause; the input is taken again as soon
// as the result stage has room, so bytes keep being received while a result
// waits. Reset clears the counters, the overflow latch and both valid flags;
// the byte stores keep undefined contents that are never read before written.
`timescale 1ns / 1ps
module ping_pong_rx_buffer #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pprb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pprb_pkg::out_item_t out_data
);

  pprb_pkg::dp_cmd_t    cmd;
  pprb_pkg::dp_status_t status;

  pprb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  pprb_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A store read only starts when the result stage can take it.
  a_read_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue || cmd.start_read) |-> status.stage_free)
    else $error("store read started without room in the result stage");

  // No input transfer while a read run is in progress.
  a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !(in_valid && in_ready))
    else $error("input transfer during a read run");

  // Results other than data bytes are always the last of their request.
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.result_kind != pprb_pkg::KIND_DATA)) |-> out_data.last_of_run)
    else $error("single result not marked last");

  // Only a status result carries the overflow flag.
  a_ovf_only_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.result_kind != pprb_pkg::KIND_STATUS)) |-> !out_data.overflow_seen)
    else $error("overflow flag on a non-status result");

endmodule

FILE: src/pprb_ctrl.sv
// Controller state machine that sequences requests and read runs of the receive buffer.
`timescale 1ns / 1ps
module pprb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          req_type,
  input  pprb_pkg::dp_status_t status,
  output logic                in_ready,
  output pprb_pkg::dp_cmd_t   cmd
);

  pprb_pkg::ctl_state_t state_r;
  pprb_pkg::ctl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pprb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      pprb_pkg::ST_IDLE: begin
        in_ready = status.stage_free;
        if (in_valid && status.stage_free) begin
          case (req_type)
            pprb_pkg::REQ_BYTE: begin
              cmd.store_byte = 1'b1;
            end
            pprb_pkg::REQ_READ: begin
              if (status.n_zero) begin
                cmd.load_none = 1'b1;
              end else begin
                cmd.start_read = 1'b1;
                if (!status.n_one) begin
                  state_nxt = pprb_pkg::ST_STREAM;
                end
              end
            end
            pprb_pkg::REQ_CHECK: begin
              cmd.load_check = 1'b1;
            end
            default: begin
              // The unused request code is taken and ignored.
            end
          endcase
        end
      end
      pprb_pkg::ST_STREAM: begin
        // One byte read per cycle while the result stage has room.
        if (status.stage_free) begin
          cmd.issue = 1'b1;
          if (status.rem_one) begin
            state_nxt = pprb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = pprb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/pprb_datapath.sv
// Datapath of the receive buffer: the two byte stores, counters, result stage and output register.
`timescale 1ns / 1ps
module pprb_datapath #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pprb_pkg::in_item_t   in_data,
  input  pprb_pkg::dp_cmd_t    cmd,
  output pprb_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pprb_pkg::out_item_t  out_data
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

  // Byte stores.
  logic [pprb_pkg::BYTE_W-1:0] mem_a [BUF_DEPTH];
  logic [pprb_pkg::BYTE_W-1:0] mem_b [BUF_DEPTH];

  // Buffer bookkeeping.
  logic [CW-1:0] fill_count_r, fill_count_nxt;
  logic [CW-1:0] ready_count_r, ready_count_nxt;
  logic [AW-1:0] read_offset_r, read_offset_nxt;
  logic          fill_is_b_r, fill_is_b_nxt;
  logic          overflow_r, overflow_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  // Result stage ahead of the output register.
  logic                        pend_r, pend_nxt;
  logic [pprb_pkg::REQ_W-1:0]  pend_kind_r;
  logic                        pend_last_r;
  logic                        pend_ovf_r;
  logic [pprb_pkg::BYTE_W-1:0] rd_q_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  pprb_pkg::out_item_t out_data_r;

  logic                            move;
  logic                            rd_en;
  logic                            rd_last;
  logic                            we;
  logic                            we_side_b;
  logic [AW-1:0]                   waddr;
  logic [pprb_pkg::LEN_W-1:0]      rc_ext;
  logic [pprb_pkg::LEN_W-1:0]      n_sel;

  // Transfer from the result stage into the output register.
  assign move = pend_r && (!out_valid_r || out_ready);

  // Run length of a read request, limited by the ready bytes.
  assign rc_ext = pprb_pkg::LEN_W'(ready_count_r);
  assign n_sel  = (in_data.read_len < rc_ext) ? in_data.read_len : rc_ext;

  assign status.stage_free = !pend_r || move;
  assign status.n_zero     = (n_sel == '0);
  assign status.n_one      = (n_sel == pprb_pkg::LEN_W'(1));
  assign status.rem_one    = (rem_r == CW'(1));

  assign rd_en   = cmd.start_read || cmd.issue;
  assign rd_last = cmd.start_read ? status.n_one : status.rem_one;

  // Counter, side and latch updates.
  always_comb begin
    fill_count_nxt  = fill_count_r;
    ready_count_nxt = ready_count_r;
    read_offset_nxt = read_offset_r;
    fill_is_b_nxt   = fill_is_b_r;
    overflow_nxt    = overflow_r;
    rem_nxt         = rem_r;
    we              = 1'b0;
    we_side_b       = fill_is_b_r;
    waddr           = fill_count_r[AW-1:0];
    if (cmd.store_byte && !overflow_r) begin
      if (fill_count_r < CW'(BUF_DEPTH)) begin
        we             = 1'b1;
        fill_count_nxt = fill_count_r + CW'(1);
        if (ready_count_r == '0) begin
          // Reader is empty: the filled part becomes readable.
          ready_count_nxt = fill_count_r + CW'(1);
          fill_count_nxt  = '0;
          read_offset_nxt = '0;
          fill_is_b_nxt   = !fill_is_b_r;
        end
      end else if (ready_count_r == '0) begin
        // Full fill side, empty reader: swap first, byte opens the new fill side.
        ready_count_nxt = fill_count_r;
        fill_count_nxt  = CW'(1);
        read_offset_nxt = '0;
        fill_is_b_nxt   = !fill_is_b_r;
        we              = 1'b1;
        we_side_b       = !fill_is_b_r;
        waddr           = '0;
      end else begin
        overflow_nxt = 1'b1;
      end
    end
    if (rd_en) begin
      ready_count_nxt = ready_count_r - CW'(1);
      read_offset_nxt = (ready_count_r == CW'(1)) ? '0 : read_offset_r + AW'(1);
      rem_nxt         = cmd.start_read ? CW'(n_sel) - CW'(1) : rem_r - CW'(1);
    end
    if (cmd.load_check && overflow_r && in_data.reinit) begin
      fill_count_nxt  = '0;
      ready_count_nxt = '0;
      read_offset_nxt = '0;
      overflow_nxt    = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r  <= '0;
      ready_count_r <= '0;
      read_offset_r <= '0;
      fill_is_b_r   <= 1'b0;
      overflow_r    <= 1'b0;
      rem_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      fill_count_r  <= fill_count_nxt;
      ready_count_r <= ready_count_nxt;
      read_offset_r <= read_offset_nxt;
      fill_is_b_r   <= fill_is_b_nxt;
      overflow_r    <= overflow_nxt;
      rem_r         <= rem_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Store writes go to the fill side.
  always_ff @(posedge clk) begin
    if (we && !we_side_b) begin
      mem_a[waddr] <= in_data.rx_byte;
    end
    if (we && we_side_b) begin
      mem_b[waddr] <= in_data.rx_byte;
    end
  end

  // Registered read from the ready side.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= fill_is_b_r ? mem_a[read_offset_r] : mem_b[read_offset_r];
    end
  end

  // Result stage tags.
  assign pend_nxt = (rd_en || cmd.load_none || cmd.load_check) ? 1'b1 :
                    (move ? 1'b0 : pend_r);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_kind_r <= pprb_pkg::KIND_DATA;
      pend_last_r <= rd_last;
      pend_ovf_r  <= 1'b0;
    end else if (cmd.load_none) begin
      pend_kind_r <= pprb_pkg::KIND_EMPTY;
      pend_last_r <= 1'b1;
      pend_ovf_r  <= 1'b0;
    end else if (cmd.load_check) begin
      pend_kind_r <= pprb_pkg::KIND_STATUS;
      pend_last_r <= 1'b1;
      pend_ovf_r  <= overflow_r;
    end
  end

  // Output register.
  assign out_valid_nxt = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r.result_kind   <= pend_kind_r;
      out_data_r.out_byte      <= (pend_kind_r == pprb_pkg::KIND_DATA) ? rd_q_r : '0;
      out_data_r.overflow_seen <= pend_ovf_r;
      out_data_r.last_of_run   <= pend_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
